// ===== src/brtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brtc_pkg: shared types, constants and calendar tables
// Request and mode codes, port addresses, command nibbles and the small
// month tables used by the calendar sequencer.
// ----------------------------------------------------------------------------
package brtc_pkg;

  localparam int unsigned DigitCount = 13;

  localparam logic [15:0] PortRead  = 16'h2800;
  localparam logic [15:0] PortWrite = 16'h2801;

  localparam logic [3:0] CmdRead    = 4'hD;
  localparam logic [3:0] CmdCommand = 4'hE;
  localparam logic [3:0] CmdNop     = 4'hF;
  localparam logic [3:0] CmdOpen    = 4'h0;
  localparam logic [3:0] CmdClear   = 4'h4;

  localparam logic [7:0] FrameByte = 8'h0F;

  localparam logic signed [4:0] PtrIdle   = -5'sd1;
  localparam logic signed [4:0] PtrLast   = 5'sd11;
  localparam logic signed [4:0] PtrFull   = 5'sd12;
  localparam logic signed [4:0] PtrDone   = 5'sd13;

  localparam logic [11:0] YearBase    = 12'd1000;
  localparam logic [11:0] YearMin     = 12'd1900;
  // 1900 plus the leap years before 1900 (460)
  localparam logic [11:0] WdayOffset  = 12'd2360;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_COMMAND = 2'd1,
    MODE_WRITE   = 2'd2,
    MODE_READY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIV_10  = 2'd0,
    DIV_100 = 2'd1,
    DIV_7   = 2'd2
  } div_t;

  // month length; months 0 and 13..15 count as 31 days
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    unique case (mon)
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // days before the first of a month 1..12 in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // remainder by 7 for values up to 20
  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd14) begin
      r = v - 5'd14;
    end else if (v >= 5'd7) begin
      r = v - 5'd7;
    end else begin
      r = v;
    end
    return r[2:0];
  endfunction

  // units plus ten times tens
  function automatic logic [7:0] dec2(input logic [3:0] lo, input logic [3:0] hi);
    return {4'd0, lo} + {1'b0, hi, 3'd0} + {3'd0, hi, 1'b0};
  endfunction

endpackage
`default_nettype wire

// ===== src/bcd_rtc_calendar_port.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_port: BCD real-time clock and calendar bus port
// Thirteen-digit BCD calendar behind a read port and a nibble command port,
// advanced by one-second ticks, with weekday recomputed after a date write.
// ----------------------------------------------------------------------------
// One beat is taken at a time and every beat returns one result beat. A bus
// read or write goes from idle to the output state, where its result is
// loaded into the output register once the result side is free. A write that
// completes the twelfth digit also runs the weekday sequence: the leap test and
// the weekday remainder each make one pass through the divide-by-constant
// unit, with the weekday sum states W_SUM1 to W_SUM3 in between. On a tick,
// the carry sequencer steps one calendar field per cycle, and the same shared
// divide-by-constant unit (one multiplier) then turns six values back into
// digits, one value per cycle.
// in_stall stays high until the result has been loaded into the output
// register.
module bcd_rtc_calendar_port
  import brtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_bus_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_open_bus,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_OUT,
    T_DEC,
    T_LEAP,
    T_SEC,
    T_MIN,
    T_HOUR,
    T_DAY,
    T_MON,
    C_SEC,
    C_MIN,
    C_HOUR,
    C_DAY,
    C_YR0,
    C_YR1,
    W_DEC,
    W_LEAP,
    W_SUM1,
    W_SUM2,
    W_SUM3,
    W_MOD
  } st_t;

  st_t               st_r, st_nxt;
  mode_t             mode_r, mode_nxt;
  logic signed [4:0] ptr_r, ptr_nxt;
  logic [3:0]        dig_r [DigitCount];
  logic [3:0]        dig_nxt [DigitCount];
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_read_data_r, out_read_data_nxt;
  logic [7:0]        res_r, res_nxt;

  logic [7:0]        sec_r, sec_nxt;
  logic [7:0]        min_r, min_nxt;
  logic [7:0]        hour_r, hour_nxt;
  logic [7:0]        day_r, day_nxt;
  logic [4:0]        mon_r, mon_nxt;
  logic [11:0]       yr_r, yr_nxt;
  logic [3:0]        wd_r, wd_nxt;
  logic              leap_r, leap_nxt;
  logic [4:0]        qm_r, qm_nxt;
  logic [11:0]       acc_r, acc_nxt;

  // shared divide-by-constant unit
  logic [11:0] unit_x;
  div_t        unit_sel;
  logic [15:0] unit_recip;
  logic [27:0] unit_prod;
  logic [11:0] unit_q;
  logic [11:0] unit_kq;
  logic [11:0] unit_diff;
  logic [6:0]  unit_r;

  logic        leap_calc;
  logic [4:0]  qm_calc;
  logic [3:0]  nib;
  logic [11:0] yr_dec;
  logic [7:0]  day_dec;
  logic [7:0]  day_inc;
  logic [11:0] yr_m1;

  assign in_stall      = (st_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  always_comb begin
    unit_x   = acc_r;
    unit_sel = DIV_10;
    unique case (st_r)
      T_LEAP, W_LEAP: begin
        unit_x   = yr_r;
        unit_sel = DIV_100;
      end
      W_MOD: begin
        unit_x   = acc_r;
        unit_sel = DIV_7;
      end
      C_SEC:  unit_x = {4'd0, sec_r};
      C_MIN:  unit_x = {4'd0, min_r};
      C_HOUR: unit_x = {4'd0, hour_r};
      C_DAY:  unit_x = {4'd0, day_r};
      C_YR0:  unit_x = yr_r - YearBase;
      default: begin
        unit_x   = acc_r;
        unit_sel = DIV_10;
      end
    endcase
  end

  always_comb begin
    unique case (unit_sel)
      DIV_100: unit_recip = 16'd5243;
      DIV_7:   unit_recip = 16'd9363;
      default: unit_recip = 16'd52429;
    endcase
    unit_prod = {16'd0, unit_x} * {12'd0, unit_recip};
    unique case (unit_sel)
      DIV_100: begin
        unit_q  = {3'd0, unit_prod[27:19]};
        unit_kq = (unit_q << 6) + (unit_q << 5) + (unit_q << 2);
      end
      DIV_7: begin
        unit_q  = unit_prod[27:16];
        unit_kq = (unit_q << 3) - unit_q;
      end
      default: begin
        unit_q  = {3'd0, unit_prod[27:19]};
        unit_kq = (unit_q << 3) + (unit_q << 1);
      end
    endcase
    unit_diff = unit_x - unit_kq;
    unit_r    = unit_diff[6:0];
  end

  // leap year and quotient of (year - 1) by 100
  assign leap_calc = (yr_r[1:0] == 2'd0) && ((unit_r != 7'd0) || (unit_q[1:0] == 2'd0));
  assign qm_calc   = (unit_r == 7'd0) ? (unit_q[4:0] - 5'd1) : unit_q[4:0];

  assign nib     = in_write_data[3:0];
  assign yr_dec  = {8'd0, dig_r[9]} + {5'd0, dig_r[10], 3'd0} + {7'd0, dig_r[10], 1'b0}
                 + {2'd0, dig_r[11], 6'd0} + {3'd0, dig_r[11], 5'd0}
                 + {6'd0, dig_r[11], 2'd0} + YearBase;
  assign day_dec = dec2(dig_r[6], dig_r[7]);
  assign day_inc = day_r + 8'd1;
  assign yr_m1   = yr_r - 12'd1;

  always_comb begin
    st_nxt            = st_r;
    mode_nxt          = mode_r;
    ptr_nxt           = ptr_r;
    dig_nxt           = dig_r;
    res_nxt           = res_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_read_data_nxt = out_read_data_r;
    sec_nxt           = sec_r;
    min_nxt           = min_r;
    hour_nxt          = hour_r;
    day_nxt           = day_r;
    mon_nxt           = mon_r;
    yr_nxt            = yr_r;
    wd_nxt            = wd_r;
    leap_nxt          = leap_r;
    qm_nxt            = qm_r;
    acc_nxt           = acc_r;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = 8'd0;
          st_nxt  = S_OUT;
          unique case (req_t'(in_req_type))
            REQ_READ: begin
              if (in_bus_address != PortRead) begin
                res_nxt = in_open_bus;
              end else if (mode_r != MODE_READ) begin
                res_nxt = 8'd0;
              end else if (ptr_r[4]) begin
                ptr_nxt = 5'sd0;
                res_nxt = FrameByte;
              end else if (ptr_r > PtrFull) begin
                ptr_nxt = PtrIdle;
                res_nxt = FrameByte;
              end else begin
                res_nxt = {4'd0, dig_r[ptr_r[3:0]]};
                ptr_nxt = ptr_r + 5'sd1;
              end
            end
            REQ_WRITE: begin
              if (in_bus_address == PortWrite) begin
                priority if (nib == CmdRead) begin
                  mode_nxt = MODE_READ;
                  ptr_nxt  = PtrIdle;
                end else if (nib == CmdCommand) begin
                  mode_nxt = MODE_COMMAND;
                end else if (nib == CmdNop) begin
                  mode_nxt = mode_r;
                end else if (mode_r == MODE_WRITE) begin
                  if (!ptr_r[4] && (ptr_r < PtrFull)) begin
                    dig_nxt[ptr_r[3:0]] = nib;
                    if (ptr_r == PtrLast) begin
                      ptr_nxt = PtrDone;
                      st_nxt  = W_DEC;
                    end else begin
                      ptr_nxt = ptr_r + 5'sd1;
                    end
                  end
                end else if (mode_r == MODE_COMMAND) begin
                  if (nib == CmdOpen) begin
                    mode_nxt = MODE_WRITE;
                    ptr_nxt  = 5'sd0;
                  end else if (nib == CmdClear) begin
                    mode_nxt = MODE_READY;
                    ptr_nxt  = PtrIdle;
                    dig_nxt  = '{default: 4'd0};
                  end else begin
                    mode_nxt = MODE_READY;
                  end
                end else begin
                  mode_nxt = mode_r;
                end
              end
            end
            REQ_TICK: st_nxt = T_DEC;
            REQ_NONE: st_nxt = S_OUT;
          endcase
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_read_data_nxt = res_r;
          st_nxt            = S_IDLE;
        end
      end

      // one-second tick
      T_DEC: begin
        sec_nxt  = dec2(dig_r[0], dig_r[1]) + 8'd1;
        min_nxt  = dec2(dig_r[2], dig_r[3]);
        hour_nxt = dec2(dig_r[4], dig_r[5]);
        day_nxt  = day_dec;
        mon_nxt  = {1'b0, dig_r[8]};
        yr_nxt   = yr_dec;
        wd_nxt   = dig_r[12];
        st_nxt   = T_LEAP;
      end
      T_LEAP: begin
        leap_nxt = leap_calc;
        st_nxt   = T_SEC;
      end
      T_SEC: begin
        if (sec_r >= 8'd60) begin
          sec_nxt = sec_r - 8'd60;
          st_nxt  = T_MIN;
        end else begin
          st_nxt = C_SEC;
        end
      end
      T_MIN: begin
        if (min_r < 8'd59) begin
          min_nxt = min_r + 8'd1;
          st_nxt  = T_SEC;
        end else begin
          min_nxt = 8'd0;
          st_nxt  = T_HOUR;
        end
      end
      T_HOUR: begin
        if (hour_r < 8'd23) begin
          hour_nxt = hour_r + 8'd1;
          st_nxt   = T_SEC;
        end else begin
          hour_nxt = 8'd0;
          st_nxt   = T_DAY;
        end
      end
      T_DAY: begin
        wd_nxt = {1'b0, mod7_small({1'b0, wd_r} + 5'd1)};
        if (day_inc <= {3'd0, month_days(mon_r[3:0], leap_r)}) begin
          day_nxt = day_inc;
          st_nxt  = T_SEC;
        end else begin
          day_nxt = 8'd1;
          st_nxt  = T_MON;
        end
      end
      T_MON: begin
        if (mon_r < 5'd12) begin
          mon_nxt = mon_r + 5'd1;
        end else begin
          mon_nxt = 5'd1;
          yr_nxt  = yr_r + 12'd1;
        end
        st_nxt = T_SEC;
      end

      // back to digits
      C_SEC: begin
        dig_nxt[0] = unit_r[3:0];
        dig_nxt[1] = unit_q[3:0];
        st_nxt     = C_MIN;
      end
      C_MIN: begin
        dig_nxt[2] = unit_r[3:0];
        dig_nxt[3] = unit_q[3:0];
        st_nxt     = C_HOUR;
      end
      C_HOUR: begin
        dig_nxt[4] = unit_r[3:0];
        dig_nxt[5] = unit_q[3:0];
        st_nxt     = C_DAY;
      end
      C_DAY: begin
        dig_nxt[6]  = unit_r[3:0];
        dig_nxt[7]  = unit_q[3:0];
        dig_nxt[8]  = mon_r[3:0];
        dig_nxt[12] = {1'b0, mod7_small({1'b0, wd_r})};
        st_nxt      = C_YR0;
      end
      C_YR0: begin
        dig_nxt[9] = unit_r[3:0];
        acc_nxt    = unit_q;
        st_nxt     = C_YR1;
      end
      C_YR1: begin
        dig_nxt[10] = unit_r[3:0];
        dig_nxt[11] = unit_q[3:0];
        st_nxt      = S_OUT;
      end

      // weekday after a full date write
      W_DEC: begin
        yr_nxt = (yr_dec < YearMin) ? YearMin : yr_dec;
        if (dig_r[8] == 4'd0) begin
          mon_nxt = 5'd1;
        end else if (dig_r[8] > 4'd12) begin
          mon_nxt = 5'd12;
        end else begin
          mon_nxt = {1'b0, dig_r[8]};
        end
        if (day_dec == 8'd0) begin
          day_nxt = 8'd1;
        end else if (day_dec > 8'd31) begin
          day_nxt = 8'd31;
        end else begin
          day_nxt = day_dec;
        end
        st_nxt = W_LEAP;
      end
      W_LEAP: begin
        leap_nxt = leap_calc;
        qm_nxt   = qm_calc;
        st_nxt   = W_SUM1;
      end
      W_SUM1: begin
        acc_nxt = yr_r + {2'd0, yr_m1[11:2]} - WdayOffset;
        st_nxt  = W_SUM2;
      end
      W_SUM2: begin
        acc_nxt = acc_r + {9'd0, qm_r[4:2]} - {7'd0, qm_r};
        st_nxt  = W_SUM3;
      end
      W_SUM3: begin
        acc_nxt = acc_r + {3'd0, cum_days(mon_r[3:0])}
                + {11'd0, (leap_r && (mon_r > 5'd2))} + {4'd0, day_r};
        st_nxt  = W_MOD;
      end
      W_MOD: begin
        dig_nxt[12] = unit_r[3:0];
        st_nxt      = S_OUT;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= S_IDLE;
      mode_r          <= MODE_READ;
      ptr_r           <= PtrIdle;
      dig_r           <= '{default: 4'd0};
      out_valid_r     <= 1'b0;
      out_read_data_r <= 8'd0;
    end else begin
      st_r            <= st_nxt;
      mode_r          <= mode_nxt;
      ptr_r           <= ptr_nxt;
      dig_r           <= dig_nxt;
      out_valid_r     <= out_valid_nxt;
      out_read_data_r <= out_read_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    day_r  <= day_nxt;
    mon_r  <= mon_nxt;
    yr_r   <= yr_nxt;
    wd_r   <= wd_nxt;
    leap_r <= leap_nxt;
    qm_r   <= qm_nxt;
    acc_r  <= acc_nxt;
  end

endmodule
`default_nettype wire

// ===== test/bcd_rtc_calendar_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_rtc_calendar_checker: predicts and checks the calendar port results
// Watches both channels of bcd_rtc_calendar_port. Every accepted request
// beat runs through a local copy of the calendar, mode and digit pointer, and
// the byte it should return is queued. Every accepted result beat is compared
// with the oldest queued byte. Failures are counted and passed to the top.
// ----------------------------------------------------------------------------
module bcd_rtc_calendar_checker
  import brtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_open_bus,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_read_data,
  output int          fail_count,
  output int          pending
);

  logic [3:0]        cal [DigitCount];
  mode_t             mode;
  logic signed [4:0] ptr;
  logic [7:0]        expected_bytes [$];

  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && !((yr % 100 == 0) && (yr % 400 != 0));
  endfunction

  // leap years in 1 .. n-1
  function automatic int unsigned leaps_until(input int unsigned n);
    int unsigned m;
    m = n - 1;
    return m / 4 - m / 100 + m / 400;
  endfunction

  // month 0 and 13..15 count as 31 days
  function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
    int unsigned len;
    case ((mo - 1) & 15)
      1:             len = leap_year(yr) ? 29 : 28;
      3, 5, 8, 10:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] day_of_week(input int unsigned yr_in, input int unsigned mo_in,
                                             input int unsigned dy_in);
    int unsigned yr, mo, dy, total, k;
    yr = (yr_in < 32'(YearMin)) ? 32'(YearMin) : yr_in;
    mo = (mo_in < 1) ? 1 : ((mo_in > 12) ? 12 : mo_in);
    dy = (dy_in < 1) ? 1 : ((dy_in > 31) ? 31 : dy_in);
    total = 365 * (yr - 32'(YearMin)) + leaps_until(yr) - leaps_until(32'(YearMin));
    for (k = 1; k < mo; k++) begin
      total += month_length(k, yr);
    end
    total += dy - 1;
    return 4'((total + 1) % 7);
  endfunction

  task automatic advance_second();
    int unsigned s, mi, h, dy, mo, yr, wd;
    s  = 32'(cal[0]) + 10 * 32'(cal[1]);
    mi = 32'(cal[2]) + 10 * 32'(cal[3]);
    h  = 32'(cal[4]) + 10 * 32'(cal[5]);
    dy = 32'(cal[6]) + 10 * 32'(cal[7]);
    mo = 32'(cal[8]);
    yr = 32'(cal[9]) + 10 * 32'(cal[10]) + 100 * 32'(cal[11]) + 32'(YearBase);
    wd = 32'(cal[12]);
    s++;
    while (s >= 60) begin
      s -= 60;
      mi++;
      if (mi >= 60) begin
        mi = 0;
        h++;
        if (h >= 24) begin
          h = 0;
          dy++;
          wd = (wd + 1) % 7;
          if (dy > month_length(mo, yr)) begin
            dy = 1;
            mo++;
            if (mo > 12) begin
              mo = 1;
              yr++;
            end
          end
        end
      end
    end
    yr -= 32'(YearBase);
    cal[0]  = 4'(s % 10);
    cal[1]  = 4'((s / 10) & 15);
    cal[2]  = 4'(mi % 10);
    cal[3]  = 4'((mi / 10) & 15);
    cal[4]  = 4'(h % 10);
    cal[5]  = 4'((h / 10) & 15);
    cal[6]  = 4'(dy % 10);
    cal[7]  = 4'((dy / 10) & 15);
    cal[8]  = 4'(mo & 15);
    cal[9]  = 4'(yr % 10);
    cal[10] = 4'((yr / 10) % 10);
    cal[11] = 4'((yr / 100) & 15);
    cal[12] = 4'(wd % 7);
  endtask

  function automatic logic [7:0] bus_read(input logic [15:0] addr, input logic [7:0] bus);
    logic [7:0] val;
    if (addr != PortRead) return bus;
    if (mode != MODE_READ) return 8'h00;
    if (ptr < 5'sd0) begin
      ptr = 5'sd0;
      return FrameByte;
    end
    if (ptr > PtrFull) begin
      ptr = PtrIdle;
      return FrameByte;
    end
    val = {4'h0, cal[ptr]};
    ptr = ptr + 5'sd1;
    return val;
  endfunction

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
    logic [3:0] nib;
    nib = data[3:0];
    if (addr != PortWrite) return;
    if (nib == CmdRead) begin
      mode = MODE_READ;
      ptr  = PtrIdle;
    end else if (nib == CmdCommand) begin
      mode = MODE_COMMAND;
    end else if (nib == CmdNop) begin
      return;
    end else if (mode == MODE_WRITE) begin
      if (ptr >= 5'sd0 && ptr <= PtrLast) begin
        cal[ptr] = nib;
        ptr = ptr + 5'sd1;
        if (ptr == PtrFull) begin
          cal[12] = day_of_week(32'(cal[9]) + 10 * 32'(cal[10]) + 100 * 32'(cal[11])
                                + 32'(YearBase), 32'(cal[8]),
                                32'(cal[6]) + 10 * 32'(cal[7]));
          ptr = PtrDone;
        end
      end
    end else if (mode == MODE_COMMAND) begin
      if (nib == CmdOpen) begin
        mode = MODE_WRITE;
        ptr  = 5'sd0;
      end else if (nib == CmdClear) begin
        mode = MODE_READY;
        ptr  = PtrIdle;
        for (int i = 0; i < DigitCount; i++) cal[i] = 4'h0;
      end else begin
        mode = MODE_READY;
      end
    end
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      for (int i = 0; i < DigitCount; i++) cal[i] = 4'h0;
      mode = MODE_READ;
      ptr  = PtrIdle;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("read_data: expected none, actual 0x%02h", out_read_data);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_read_data !== want) begin
            $error("read_data: expected 0x%02h, actual 0x%02h", want, out_read_data);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = 8'h00;
        case (req_t'(in_req_type))
          REQ_READ:  want = bus_read(in_bus_address, in_open_bus);
          REQ_WRITE: bus_write(in_bus_address, in_write_data);
          REQ_TICK:  advance_second();
          default:   want = 8'h00;
        endcase
        expected_bytes.push_back(want);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== test/tb_bcd_rtc_calendar_port.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bcd_rtc_calendar_port: stimulus and verdict for the calendar bus port
// Drives bus reads, nibble commands, date writes and one-second ticks with
// random gaps on both channels, two long result hold-offs, and leaves the
// checking to bcd_rtc_calendar_checker.
// ----------------------------------------------------------------------------
module tb_bcd_rtc_calendar_port;
  import brtc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 1050;
  localparam logic [3:0]  CmdUnknown  = 4'h7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_READ;
  logic [15:0] in_bus_address = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;
  logic [7:0]  in_open_bus = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;

  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned results_taken = 0;
  bit          steady = 1'b0;

  always #10 clk = ~clk;

  bcd_rtc_calendar_port u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_open_bus    (in_open_bus),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data)
  );

  bcd_rtc_calendar_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_bus_address (in_bus_address),
    .in_write_data  (in_write_data),
    .in_open_bus    (in_open_bus),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input req_t req, input logic [15:0] addr, input logic [7:0] data,
                      input logic [7:0] bus);
    int unsigned gap;
    bit          held;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_bus_address <= addr;
    in_write_data  <= data;
    in_open_bus    <= bus;
    forever begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
      if (!held) break;
    end
    beats_sent++;
  endtask

  task automatic port_write(input logic [3:0] nib);
    send(REQ_WRITE, PortWrite, {4'($urandom), nib}, 8'($urandom));
  endtask

  task automatic port_read();
    send(REQ_READ, PortRead, 8'($urandom), 8'($urandom));
  endtask

  task automatic tick();
    send(REQ_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic noise_beat();
    logic [15:0] addr;
    case ($urandom_range(0, 2))
      0:       addr = PortRead;
      1:       addr = PortWrite;
      default: addr = 16'($urandom);
    endcase
    send(req_t'(2'($urandom_range(0, 3))), addr, 8'($urandom), 8'($urandom));
  endtask

  // date write, leaning toward month, year and day boundaries
  task automatic write_date();
    int unsigned sec, mnt, hr, dy, mo, yr;
    logic [3:0]  dig [12];
    bool_edge: begin end
    case ($urandom_range(0, 5))
      0, 1:    mo = 2;
      2:       mo = 12;
      default: mo = $urandom_range(0, 12);
    endcase
    case ($urandom_range(0, 5))
      0:       yr = 999;
      1:       yr = 900;
      2:       yr = 600;
      3:       yr = 996;
      4:       yr = 4 * $urandom_range(0, 249);
      default: yr = $urandom_range(0, 999);
    endcase
    dy = ($urandom_range(0, 1) != 0) ? $urandom_range(28, 31) : $urandom_range(0, 31);
    if ($urandom_range(0, 2) == 0) begin
      sec = 59;
      mnt = 59;
      hr  = 23;
    end else begin
      sec = ($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59);
      mnt = ($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59);
      hr  = ($urandom_range(0, 1) != 0) ? 23 : $urandom_range(0, 23);
    end
    dig[0]  = 4'(sec % 10);
    dig[1]  = 4'(sec / 10);
    dig[2]  = 4'(mnt % 10);
    dig[3]  = 4'(mnt / 10);
    dig[4]  = 4'(hr % 10);
    dig[5]  = 4'(hr / 10);
    dig[6]  = 4'(dy % 10);
    dig[7]  = 4'(dy / 10);
    dig[8]  = 4'(mo);
    dig[9]  = 4'(yr % 10);
    dig[10] = 4'((yr / 10) % 10);
    dig[11] = 4'(yr / 100);
    // non-decimal digit
    if ($urandom_range(0, 7) == 0) dig[$urandom_range(0, 11)] = 4'($urandom_range(10, 12));
    port_write(CmdCommand);
    port_write(CmdOpen);
    for (int k = 0; k < 12; k++) port_write(dig[k]);
  endtask

  // result side: random hold per beat, long hold-offs twice
  initial begin
    int unsigned wait_n;
    bit          seen;
    forever begin
      wait_n = steady ? 0 : $urandom_range(0, 5);
      if (results_taken == 300 || results_taken == 750) wait_n = 300;
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
        if (seen) break;
      end
      results_taken++;
    end
  end

  initial begin
    int unsigned stop_at;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    port_read();
    send(REQ_READ, 16'h0000, 8'h00, 8'hFF);
    send(REQ_READ, 16'hFFFF, 8'hFF, 8'h00);
    send(REQ_NONE, PortRead, 8'hFF, 8'hA5);
    send(REQ_WRITE, PortWrite, 8'hFF, 8'h00);
    send(REQ_WRITE, PortWrite, 8'h05, 8'h00);
    port_write(CmdCommand);
    port_write(CmdUnknown);
    port_read();
    port_write(CmdCommand);
    port_write(CmdClear);
    port_write(CmdCommand);
    port_write(CmdOpen);
    // 23:59:59 on the last day of 1999
    port_write(4'd9);
    port_write(4'd5);
    port_write(4'd9);
    port_write(4'd5);
    port_write(4'd3);
    port_write(4'd2);
    port_write(4'd1);
    port_write(4'd3);
    port_write(4'd12);
    port_write(4'd9);
    port_write(4'd9);
    port_write(4'd9);
    tick();

    stop_at = beats_sent + RandomItems;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) steady = !steady;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          write_date();
          repeat ($urandom_range(0, 3)) tick();
          port_write(CmdRead);
          repeat ($urandom_range(1, 16)) port_read();
        end
        3, 4: begin
          repeat ($urandom_range(1, 8)) tick();
        end
        5: begin
          repeat ($urandom_range(1, 16)) port_read();
        end
        6: begin
          port_write(CmdCommand);
          port_write(CmdClear);
          port_write(CmdRead);
        end
        7: begin
          port_write(CmdCommand);
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 2) != 0) port_write(4'($urandom_range(0, 15)));
            else port_read();
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) noise_beat();
        end
      endcase
    end
    in_valid <= 1'b0;

    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
